FILE: sv/dirty_tracked_value_table_core_assert.svh
// Assertion macros for the dirty-tracked value table core.
// Included by the top level, the RTL file that carries concurrent checks; no other dependencies.
`ifndef DIRTY_TRACKED_VALUE_TABLE_CORE_ASSERT_SVH
`define DIRTY_TRACKED_VALUE_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted (active low)
`define DTVT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dtvt check failed");

// Next-cycle implication, disabled while reset is asserted (active low)
`define DTVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dtvt check failed");

`endif

FILE: sv/dtvt_pkg.sv
// Shared types and constants for the dirty-tracked value table core.
// No dependencies; imported by dtvt_table and the top level.
package dtvt_pkg;

    // default table depth and field widths
    localparam int DTVT_TABLE_SIZE = 32;
    localparam int ENTRY_W         = 5;
    localparam int INDEX_W         = 8;
    localparam int VALUE_W         = 32;

    // input word kinds
    typedef enum logic [1:0] {
        KIND_SET        = 2'd0,
        KIND_READ_DIRTY = 2'd1,
        KIND_READ_ALL   = 2'd2,
        KIND_APPLY      = 2'd3
    } t_kind;

    // input word
    typedef struct packed {
        t_kind                      kind;
        logic [INDEX_W-1:0]         index;
        logic signed [VALUE_W-1:0]  value;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [ENTRY_W-1:0]         entry_index;
        logic signed [VALUE_W-1:0]  read_value;
        logic signed [VALUE_W-1:0]  old_value;
        logic                       change_note;
        logic                       empty_res;
        logic                       last;
    } t_res_word;

    // sequencer to table request
    typedef struct packed {
        logic [ENTRY_W-1:0]         rd_addr;
        logic                       wr_en;
        logic                       set_dirty;
        logic [ENTRY_W-1:0]         wr_addr;
        logic signed [VALUE_W-1:0]  wr_data;
    } t_tbl_req;

endpackage

FILE: sv/dtvt_table.sv
// Value memory with per-entry valid bits and the dirty mask.
// Depends on dtvt_pkg for the request struct and field widths.
module dtvt_table #(
    parameter int TABLE_SIZE = dtvt_pkg::DTVT_TABLE_SIZE
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  dtvt_pkg::t_tbl_req                 i_req,
    output logic signed [dtvt_pkg::VALUE_W-1:0] o_rd_data,
    output logic [TABLE_SIZE-1:0]              o_dirty
);
    import dtvt_pkg::*;

    localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

    logic signed [VALUE_W-1:0] r_mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0]     r_valid;
    logic [TABLE_SIZE-1:0]     r_dirty;
    logic signed [VALUE_W-1:0] r_rd_data;

    logic [AW-1:0] rd_a;
    logic [AW-1:0] wr_a;

    assign rd_a = i_req.rd_addr[AW-1:0];
    assign wr_a = i_req.wr_addr[AW-1:0];

    // payload memory: write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[wr_a] <= i_req.wr_data;
        end
        r_rd_data <= r_valid[rd_a] ? r_mem[rd_a] : '0;
    end

    // valid and dirty bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_dirty <= '0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[wr_a] <= 1'b1;
            end
            if (i_req.wr_en && i_req.set_dirty) begin
                r_dirty[wr_a] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_dirty   = r_dirty;

endmodule

FILE: sv/dirty_tracked_value_table_core.sv
// Dirty-tracked value table: top level with the item sequencer.
// Depends on dtvt_pkg, dtvt_table and dirty_tracked_value_table_core_assert.svh.
//
// Usage
//   Input: drive i_word and raise start; the word is taken at a clock edge
//   where start is high and busy is low. Result words appear on o_res for
//   one cycle with o_strobe high; the receiver must take them as they come.
//   Set: busy for one cycle after acceptance (read old value, compare,
//   write); no result.
//   Apply: busy for one cycle; one result (change_note, last) is registered
//   from the look state. Out-of-range set or apply is dropped at acceptance.
//   Read changed / read all: the sequencer walks every entry through the
//   single memory read port, one entry per cycle, with busy high for the
//   whole walk; each reported entry shows in the cycle after its read
//   is issued, last marks the final one. A read of changed entries with no
//   dirty entry gives one empty result the cycle after acceptance.
//   Dirty bits are never cleared by reads.
// Reset
//   Synchronous, active low: sequencer idle, every entry reads as zero
//   and every dirty bit is clear; no clearing pass is needed.
module dirty_tracked_value_table_core #(
    parameter int TABLE_SIZE = dtvt_pkg::DTVT_TABLE_SIZE
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  dtvt_pkg::t_in_word  i_word,
    output logic                busy,
    output logic                o_strobe,
    output dtvt_pkg::t_res_word o_res
);
    import dtvt_pkg::*;

`include "dirty_tracked_value_table_core_assert.svh"

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOOK = 3'b010,
        ST_SCAN = 3'b100
    } t_state;

    localparam logic [ENTRY_W-1:0] LAST_ADDR = ENTRY_W'(TABLE_SIZE - 1);

    t_state                    r_state, n_state;
    t_kind                     r_kind, n_kind;
    logic [ENTRY_W-1:0]        r_idx, n_idx;
    logic signed [VALUE_W-1:0] r_val, n_val;
    logic [ENTRY_W-1:0]        r_addr, n_addr;
    logic                      r_strobe, n_strobe;
    logic                      r_use_rd, n_use_rd;
    t_res_word                 r_res, n_res;

    t_tbl_req                  req;
    logic signed [VALUE_W-1:0] rd_data;
    logic [TABLE_SIZE-1:0]     dirty;
    logic [TABLE_SIZE-1:0]     cur_mask;
    logic [TABLE_SIZE-1:0]     hi_mask;
    logic                      accept;
    logic                      in_range;
    logic                      cur_dirty;
    logic                      more_dirty;

    dtvt_table #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .o_rd_data (rd_data),
        .o_dirty   (dirty)
    );

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign in_range = (i_word.index < INDEX_W'(TABLE_SIZE));

    // position masks for the scan address: current entry and entries above it
    always_comb begin
        for (int j = 0; j < TABLE_SIZE; j++) begin
            cur_mask[j] = (ENTRY_W'(j) == r_addr);
            hi_mask[j]  = (ENTRY_W'(j) > r_addr);
        end
    end

    assign cur_dirty  = |(dirty & cur_mask);
    assign more_dirty = |(dirty & hi_mask);

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_idx    = r_idx;
        n_val    = r_val;
        n_addr   = r_addr;
        n_strobe = 1'b0;
        n_use_rd = r_use_rd;
        n_res    = r_res;

        req.rd_addr   = (r_state == ST_IDLE) ? i_word.index[ENTRY_W-1:0] : r_addr;
        req.wr_en     = 1'b0;
        req.set_dirty = 1'b0;
        req.wr_addr   = r_idx;
        req.wr_data   = r_val;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_kind = i_word.kind;
                    n_idx  = i_word.index[ENTRY_W-1:0];
                    n_val  = i_word.value;
                    case (i_word.kind)
                        KIND_SET, KIND_APPLY: begin
                            if (in_range) begin
                                n_state = ST_LOOK;
                            end
                        end
                        KIND_READ_DIRTY, KIND_READ_ALL: begin
                            if ((i_word.kind == KIND_READ_DIRTY) && (dirty == '0)) begin
                                // nothing to report: one empty word
                                n_strobe = 1'b1;
                                n_use_rd = 1'b0;
                                n_res    = '0;
                                n_res.empty_res = 1'b1;
                                n_res.last      = 1'b1;
                            end else begin
                                n_state = ST_SCAN;
                                n_addr  = '0;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LOOK: begin
                // old value is on the read port now
                if (r_kind == KIND_APPLY) begin
                    req.wr_en = 1'b1;
                    n_strobe  = 1'b1;
                    n_use_rd  = 1'b0;
                    n_res.entry_index = r_idx;
                    n_res.read_value  = r_val;
                    n_res.old_value   = rd_data;
                    n_res.change_note = 1'b1;
                    n_res.empty_res   = 1'b0;
                    n_res.last        = 1'b1;
                end else if ((r_val != rd_data) || (r_val == '0)) begin
                    req.wr_en     = 1'b1;
                    req.set_dirty = 1'b1;
                end
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                // read issued at r_addr; the word goes out with the read data
                n_strobe = (r_kind == KIND_READ_ALL) || cur_dirty;
                n_use_rd = 1'b1;
                n_res    = '0;
                n_res.entry_index = r_addr;
                n_res.last        = (r_kind == KIND_READ_ALL) ? (r_addr == LAST_ADDR)
                                                              : !more_dirty;
                if (r_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
            r_use_rd <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_use_rd <= n_use_rd;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_idx  <= n_idx;
        r_val  <= n_val;
        r_addr <= n_addr;
        r_res  <= n_res;
    end

    // result word: scan words take their value straight from the read register
    always_comb begin
        o_res = r_res;
        if (r_use_rd) begin
            o_res.read_value = rd_data;
        end
    end

    assign o_strobe = r_strobe;

    // checks
    `DTVT_ASSERT_NOW(a_empty_is_last, i_clk, i_rst_n, o_strobe && o_res.empty_res, o_res.last)
    `DTVT_ASSERT_NOW(a_apply_word, i_clk, i_rst_n, o_strobe && o_res.change_note, o_res.last && !o_res.empty_res)
    `DTVT_ASSERT_NEXT(a_set_silent, i_clk, i_rst_n, accept && (i_word.kind == KIND_SET), !o_strobe)
    `DTVT_ASSERT_NEXT(a_scan_busy, i_clk, i_rst_n, (r_state == ST_SCAN) && (r_addr != LAST_ADDR), busy)

endmodule

FILE: dv/tb_dirty_tracked_value_table_core.sv
// Self-checking bench for dirty_tracked_value_table_core: directed words, then random traffic.
// Keeps a shadow copy of the table and its dirty bits to predict every result word.
// Depends on dtvt_pkg and the core RTL only.
module tb_dirty_tracked_value_table_core;
    import dtvt_pkg::*;

    localparam int TBL_N       = DTVT_TABLE_SIZE;
    localparam int RAND_WORDS  = 320;
    localparam int CYCLE_LIMIT = 200000;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_word  i_word  = '0;
    logic      busy;
    logic      o_strobe;
    t_res_word o_res;

    // shadow table and dirty bits
    logic signed [VALUE_W-1:0] shadow_vals [TBL_N];
    logic [TBL_N-1:0]          shadow_dirty = '0;

    // result words still owed by the core, oldest first
    t_res_word due_reports[$];
    t_res_word head_rep;

    int n_fail    = 0;
    int cycle_cnt = 0;
    bit gaps_on   = 1'b1;

    dirty_tracked_value_table_core i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_word   (i_word),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    // 8-unit clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // update the shadow table for one accepted word and queue what it reports
    function automatic void track_table_word(input t_in_word w);
        t_res_word rep;
        int        hits;
        int        final_i;
        rep     = '0;
        hits    = 0;
        final_i = 0;
        case (w.kind)
            KIND_SET: begin
                // zero always re-marks the entry, otherwise only a change does
                if (w.index < TBL_N) begin
                    if (w.value != shadow_vals[w.index[ENTRY_W-1:0]] || w.value == 0) begin
                        shadow_dirty[w.index[ENTRY_W-1:0]] = 1'b1;
                        shadow_vals[w.index[ENTRY_W-1:0]]  = w.value;
                    end
                end
            end
            KIND_APPLY: begin
                // remote value: stored, dirty bit untouched, one change note
                if (w.index < TBL_N) begin
                    rep.entry_index = w.index[ENTRY_W-1:0];
                    rep.read_value  = w.value;
                    rep.old_value   = shadow_vals[w.index[ENTRY_W-1:0]];
                    rep.change_note = 1'b1;
                    rep.last        = 1'b1;
                    due_reports.push_back(rep);
                    shadow_vals[w.index[ENTRY_W-1:0]] = w.value;
                end
            end
            default: begin
                // scan in index order; find the final reported entry first
                for (int i = 0; i < TBL_N; i++) begin
                    if (w.kind == KIND_READ_ALL || shadow_dirty[i]) begin
                        hits++;
                        final_i = i;
                    end
                end
                if (hits == 0) begin
                    rep.empty_res = 1'b1;
                    rep.last      = 1'b1;
                    due_reports.push_back(rep);
                end else begin
                    for (int i = 0; i < TBL_N; i++) begin
                        if (w.kind == KIND_READ_ALL || shadow_dirty[i]) begin
                            rep             = '0;
                            rep.entry_index = i[ENTRY_W-1:0];
                            rep.read_value  = shadow_vals[i];
                            rep.last        = (i == final_i);
                            due_reports.push_back(rep);
                        end
                    end
                end
            end
        endcase
    endfunction

    // offer one word, optionally after a short idle gap; start stays high on return
    task automatic send_word(input t_kind k, input logic [INDEX_W-1:0] idx,
                             input logic signed [VALUE_W-1:0] val);
        t_in_word w;
        w.kind  = k;
        w.index = idx;
        w.value = val;
        if (gaps_on && $urandom_range(99) < 12) begin
            start <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_word <= w;
        do @(posedge i_clk); while (busy);
        track_table_word(w);
    endtask

    // drop start and wait until every owed result word has arrived
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (due_reports.size() != 0);
    endtask

    // reads on a clean table: empty report, then all zeros
    task automatic test_empty_reads();
        send_word(KIND_READ_DIRTY, 8'd0, 32'sd0);
        send_word(KIND_READ_ALL, 8'd0, 32'sd0);
        wait_drained();
    endtask

    // apply on a clean entry must not mark it
    task automatic test_apply_reports();
        send_word(KIND_APPLY, 8'd5, 32'h7FFF_FFFF);
        send_word(KIND_READ_DIRTY, 8'd0, 32'sd0);
        wait_drained();
    endtask

    // zero marks even when equal, equal nonzero leaves things as they are
    task automatic test_set_rules();
        send_word(KIND_SET, 8'd0, 32'sd0);
        send_word(KIND_SET, 8'd31, 32'h8000_0000);
        send_word(KIND_SET, 8'd31, 32'h8000_0000);
        send_word(KIND_SET, 8'd5, 32'h7FFF_FFFF);
        send_word(KIND_READ_DIRTY, 8'd0, 32'sd0);
        wait_drained();
    endtask

    // indexes past the table are dropped silently
    task automatic test_out_of_range();
        send_word(KIND_SET, 8'd32, 32'hFFFF_FFFF);
        send_word(KIND_SET, 8'd255, 32'sd1);
        send_word(KIND_APPLY, 8'd255, 32'hFFFF_FFFF);
        send_word(KIND_APPLY, 8'd32, 32'sd5);
        send_word(KIND_APPLY, 8'd0, 32'hFFFF_FFFF);
        send_word(KIND_READ_ALL, 8'd0, 32'sd0);
        wait_drained();
    endtask

    // a few more dirty entries with alternating bit patterns
    task automatic test_dirty_scan();
        send_word(KIND_SET, 8'd17, 32'hAAAA_AAAA);
        send_word(KIND_SET, 8'd10, 32'h5555_5555);
        send_word(KIND_APPLY, 8'd17, 32'h8000_0000);
        send_word(KIND_READ_DIRTY, 8'd0, 32'sd0);
        wait_drained();
    endtask

    // random mix; values lean on zero, the stored value and the extremes
    task automatic test_random_traffic();
        int                        sel;
        t_kind                     k;
        logic [INDEX_W-1:0]        idx;
        logic signed [VALUE_W-1:0] val;
        for (int n = 0; n < RAND_WORDS; n++) begin
            gaps_on = !(n >= 120 && n < 220);
            sel = $urandom_range(99);
            k = (sel < 45) ? KIND_SET : (sel < 70) ? KIND_APPLY :
                (sel < 85) ? KIND_READ_DIRTY : KIND_READ_ALL;
            if ($urandom_range(99) < 80) idx = INDEX_W'($urandom_range(TBL_N - 1));
            else idx = INDEX_W'($urandom_range(255, TBL_N));
            sel = $urandom_range(99);
            if (sel < 20) val = 32'sd0;
            else if (sel < 40 && idx < TBL_N) val = shadow_vals[idx[ENTRY_W-1:0]];
            else if (sel < 50) val = 32'h8000_0000;
            else if (sel < 60) val = 32'h7FFF_FFFF;
            else if (sel < 65) val = 32'hFFFF_FFFF;
            else val = $urandom;
            send_word(k, idx, val);
        end
        wait_drained();
    endtask

    // compare each strobed result word with the oldest owed one
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (due_reports.size() == 0) begin
                $error("unexpected result word: entry_index %0d read_value %0d",
                       o_res.entry_index, o_res.read_value);
                n_fail++;
            end else begin
                head_rep = due_reports.pop_front();
                if (o_res.entry_index !== head_rep.entry_index) begin
                    $error("entry_index: expected %0d, got %0d",
                           head_rep.entry_index, o_res.entry_index);
                    n_fail++;
                end
                if (o_res.read_value !== head_rep.read_value) begin
                    $error("read_value: expected %0d, got %0d",
                           head_rep.read_value, o_res.read_value);
                    n_fail++;
                end
                if (o_res.old_value !== head_rep.old_value) begin
                    $error("old_value: expected %0d, got %0d",
                           head_rep.old_value, o_res.old_value);
                    n_fail++;
                end
                if (o_res.change_note !== head_rep.change_note) begin
                    $error("change_note: expected %0b, got %0b",
                           head_rep.change_note, o_res.change_note);
                    n_fail++;
                end
                if (o_res.empty_res !== head_rep.empty_res) begin
                    $error("empty_res: expected %0b, got %0b",
                           head_rep.empty_res, o_res.empty_res);
                    n_fail++;
                end
                if (o_res.last !== head_rep.last) begin
                    $error("last: expected %0b, got %0b", head_rep.last, o_res.last);
                    n_fail++;
                end
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("FAIL dirty_tracked_value_table_core");
        $finish;
    end

    // test sequence
    initial begin
        for (int i = 0; i < TBL_N; i++) shadow_vals[i] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_reads();
        test_apply_reports();
        test_set_rules();
        test_out_of_range();
        test_dirty_scan();
        test_random_traffic();
        // let any stray words show up
        repeat (TBL_N + 8) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("PASS dirty_tracked_value_table_core");
        end else begin
            $display("FAIL dirty_tracked_value_table_core");
        end
        $finish;
    end

endmodule

FILE: dirty_tracked_value_table_core.f
+incdir+sv
sv/dtvt_pkg.sv
sv/dtvt_table.sv
sv/dirty_tracked_value_table_core.sv
dv/tb_dirty_tracked_value_table_core.sv
